[design/hfcc_pkg.sv]
// ----------------------------------------------------------------------------
// hfcc_pkg
// Shared types, constants and the CRC-8 byte step of the frame converter.
// ----------------------------------------------------------------------------
package hfcc_pkg;

    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [7:0]  CRC_POLY    = 8'h31;

    localparam logic [2:0]  POS_T_HI    = 3'd0;
    localparam logic [2:0]  POS_T_LO    = 3'd1;
    localparam logic [2:0]  POS_T_CRC   = 3'd2;
    localparam logic [2:0]  POS_H_HI    = 3'd3;
    localparam logic [2:0]  POS_H_LO    = 3'd4;
    localparam logic [2:0]  POS_H_CRC   = 3'd5;

    localparam logic [1:0]  ERR_OK      = 2'd0;
    localparam logic [1:0]  ERR_SHORT   = 2'd1;
    localparam logic [1:0]  ERR_T_CRC   = 2'd2;
    localparam logic [1:0]  ERR_H_CRC   = 2'd3;

    // fixed-point scaling
    localparam int          TPROD_W     = 29;
    localparam int          HPROD_W     = 26;
    localparam int          TEMP_SHIFT  = 14;
    localparam int          HUM_SHIFT   = 12;
    localparam logic [12:0] TEMP_SCALE  = 13'd4375;
    localparam logic [9:0]  HUM_SCALE   = 10'd625;
    localparam logic signed [15:0] TEMP_OFFSET = 16'sd4500;

    // one checked frame, handed from front to back
    typedef struct packed {
        logic [15:0] temp_raw;
        logic [15:0] hum_raw;
        logic [1:0]  err;
    } t_job;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [13:0]        humidity_centi;
        logic [1:0]         error_code;
    } t_result;

    // CRC-8, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

[design/humidity_frame_crc_converter.sv]
// ----------------------------------------------------------------------------
// humidity_frame_crc_converter
// Checks and converts the six-byte temperature/humidity sensor frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: one beat per received byte, taken when
//   push is high and full is low. i_read_failed on a beat aborts the frame
//   (i_rx_byte ignored) and yields a short-read result at once.
//   Output side is a queue read port: while empty is low the oldest result
//   sits on o_temperature_centi / o_humidity_centi / o_error_code; it is
//   taken when pop is high.
//   Frame: temp hi, temp lo, temp CRC, hum hi, hum lo, hum CRC. CRC-8,
//   poly 0x31, init 0xFF. A full frame gives a result only at its sixth byte.
//   Values read zero on any error; temperature CRC is reported first.
// Timing:
//   One byte per cycle sustained while full is low. A result passes from the
//   job queue, written on the beat that completes (or aborts) the frame, to
//   the multiply stage and then to the output queue, where it is visible.
// Stalls: the job queue and output queue (2**QAW entries each) absorb a
//   stalled receiver; full rises only once the job queue fills.
// Reset: synchronous, active low; frame restarts at byte 0, queues empty.
// ----------------------------------------------------------------------------
module humidity_frame_crc_converter
    import hfcc_pkg::*;
#(
    parameter int QAW = 1
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [7:0]         i_rx_byte,
    input  logic               i_read_failed,
    output logic               empty,
    input  logic               pop,
    output logic signed [14:0] o_temperature_centi,
    output logic [13:0]        o_humidity_centi,
    output logic [1:0]         o_error_code
);

    logic    accept;
    logic    job_valid;
    t_job    job_in;
    t_job    job_out;
    logic    job_empty;
    logic    job_pop;
    t_result result;

    // full is taken straight from the job queue, so no byte is lost
    assign accept = push && !full;

    hfcc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_rx_byte     (i_rx_byte),
        .i_read_failed (i_read_failed),
        .o_job_valid   (job_valid),
        .o_job         (job_in)
    );

    // decouples framing from scaling
    hfcc_fifo #(
        .AW (QAW),
        .T  (t_job)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    hfcc_back #(
        .AW (QAW)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .i_job       (job_out),
        .o_job_pop   (job_pop),
        .o_result    (result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

    assign o_temperature_centi = result.temperature_centi;
    assign o_humidity_centi    = result.humidity_centi;
    assign o_error_code        = result.error_code;

endmodule

[design/hfcc_fifo.sv]
// ----------------------------------------------------------------------------
// hfcc_fifo
// Small first-in first-out queue of 2**AW entries, fall-through read.
// ----------------------------------------------------------------------------
module hfcc_fifo #(
    parameter int  AW = 1,
    parameter type T  = logic [7:0]
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output T     o_data,
    output logic o_empty
);

    localparam int DEPTH = 1 << AW;

    T             r_mem [DEPTH];
    logic [AW:0]  r_wr;
    logic [AW:0]  r_rd;
    logic         do_push;
    logic         do_pop;

    assign o_full  = (r_wr[AW] != r_rd[AW]) && (r_wr[AW-1:0] == r_rd[AW-1:0]);
    assign o_empty = (r_wr == r_rd);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd[AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr[AW-1:0]] <= i_data;
        end
    end

endmodule

[design/hfcc_front.sv]
// ----------------------------------------------------------------------------
// hfcc_front
// Byte framing, CRC checking and word assembly; issues one job per frame.
// ----------------------------------------------------------------------------
module hfcc_front
    import hfcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  logic       i_read_failed,
    output logic       o_job_valid,
    output t_job       o_job
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic        r_tbad, n_tbad;
    logic [15:0] r_temp, n_temp;
    logic [7:0]  r_hum_hi, n_hum_hi;
    logic [7:0]  r_hum_lo, n_hum_lo;
    logic [2:0]  pos_eff;
    logic [7:0]  crc_next;
    logic        hbad;

    // positions six and seven fold back to the frame start
    assign pos_eff  = (r_pos > POS_H_CRC) ? POS_T_HI : r_pos;
    assign crc_next = crc8_step(r_crc, i_rx_byte);
    assign hbad     = (i_rx_byte != r_crc);

    always_comb begin
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_tbad      = r_tbad;
        n_temp      = r_temp;
        n_hum_hi    = r_hum_hi;
        n_hum_lo    = r_hum_lo;
        o_job_valid = 1'b0;
        o_job       = '{temp_raw: r_temp, hum_raw: {r_hum_hi, r_hum_lo}, err: ERR_OK};
        if (i_accept) begin
            if (i_read_failed) begin
                n_pos       = POS_T_HI;
                n_crc       = CRC_INIT;
                n_tbad      = 1'b0;
                o_job_valid = 1'b1;
                o_job.err   = ERR_SHORT;
            end else begin
                n_pos = pos_eff + 3'd1;
                case (pos_eff)
                    POS_T_HI: begin
                        n_temp[15:8] = i_rx_byte;
                        n_crc        = crc_next;
                    end
                    POS_T_LO: begin
                        n_temp[7:0] = i_rx_byte;
                        n_crc       = crc_next;
                    end
                    POS_T_CRC: begin
                        n_tbad = (i_rx_byte != r_crc);
                        n_crc  = CRC_INIT;
                    end
                    POS_H_HI: begin
                        n_hum_hi = i_rx_byte;
                        n_crc    = crc_next;
                    end
                    POS_H_LO: begin
                        n_hum_lo = i_rx_byte;
                        n_crc    = crc_next;
                    end
                    default: begin
                        o_job_valid = 1'b1;
                        o_job.err   = r_tbad ? ERR_T_CRC : (hbad ? ERR_H_CRC : ERR_OK);
                        n_pos       = POS_T_HI;
                        n_crc       = CRC_INIT;
                        n_tbad      = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= POS_T_HI;
            r_crc    <= CRC_INIT;
            r_tbad   <= 1'b0;
            r_temp   <= '0;
            r_hum_hi <= '0;
            r_hum_lo <= '0;
        end else begin
            r_pos    <= n_pos;
            r_crc    <= n_crc;
            r_tbad   <= n_tbad;
            r_temp   <= n_temp;
            r_hum_hi <= n_hum_hi;
            r_hum_lo <= n_hum_lo;
        end
    end

endmodule

[design/hfcc_back.sv]
// ----------------------------------------------------------------------------
// hfcc_back
// Scales raw words to centi-units (multiply stage, then shift/offset) and
// queues results for the receiver.
// ----------------------------------------------------------------------------
module hfcc_back
    import hfcc_pkg::*;
#(
    parameter int AW = 1
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_empty,
    input  t_job    i_job,
    output logic    o_job_pop,
    output t_result o_result,
    output logic    o_empty,
    input  logic    i_pop
);

    logic               r_s1_valid;
    logic [TPROD_W-1:0] r_s1_tprod;
    logic [HPROD_W-1:0] r_s1_hprod;
    logic [1:0]         r_s1_err;
    logic               s1_ready;
    logic               out_full;
    logic [14:0]        t_quot;
    logic signed [15:0] t_centi;
    t_result            res;

    assign s1_ready  = !r_s1_valid || !out_full;
    assign o_job_pop = s1_ready && !i_job_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= !i_job_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_tprod <= TPROD_W'(TEMP_SCALE) * TPROD_W'(i_job.temp_raw);
            r_s1_hprod <= HPROD_W'(HUM_SCALE) * HPROD_W'(i_job.hum_raw);
            r_s1_err   <= i_job.err;
        end
    end

    assign t_quot  = r_s1_tprod[TPROD_W-1:TEMP_SHIFT];
    assign t_centi = signed'({1'b0, t_quot}) - TEMP_OFFSET;

    always_comb begin
        res.error_code        = r_s1_err;
        res.temperature_centi = '0;
        res.humidity_centi    = '0;
        if (r_s1_err == ERR_OK) begin
            res.temperature_centi = t_centi[14:0];
            res.humidity_centi    = r_s1_hprod[HPROD_W-1:HUM_SHIFT];
        end
    end

    hfcc_fifo #(
        .AW (AW),
        .T  (t_result)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (res),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (o_result),
        .o_empty (o_empty)
    );

endmodule

[design/hfcc_checker.sv]
// ----------------------------------------------------------------------------
// hfcc_checker
// Port-level checks on the frame converter, bound to the top level.
// ----------------------------------------------------------------------------
module hfcc_checker
    import hfcc_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               empty,
    input logic               pop,
    input logic signed [14:0] o_temperature_centi,
    input logic [13:0]        o_humidity_centi,
    input logic [1:0]         o_error_code
);

    // the result queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    // any error zeroes both values
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code != ERR_OK) |->
            (o_temperature_centi == 15'sd0 && o_humidity_centi == 14'd0))
        else $error("error result carries non-zero values");

    // good frames stay in the sensor range
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_error_code == ERR_OK) |->
            (o_temperature_centi >= -15'sd4500 && o_temperature_centi <= 15'sd12999
             && o_humidity_centi <= 14'd9999))
        else $error("converted value out of range");

    // a waiting beat holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=>
            (!empty && $stable(o_temperature_centi) && $stable(o_humidity_centi)
             && $stable(o_error_code)))
        else $error("waiting result changed before pop");

endmodule

bind humidity_frame_crc_converter hfcc_checker u_hfcc_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .empty               (empty),
    .pop                 (pop),
    .o_temperature_centi (o_temperature_centi),
    .o_humidity_centi    (o_humidity_centi),
    .o_error_code        (o_error_code)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Drives byte beats into the temperature/humidity frame converter and checks
// every reading against an in-bench prediction of CRC checks and scaling.
// Directed frames cover the raw-word extremes, CRC failures and short reads.
// Random frames follow, most of them well formed and some corrupted, aborted
// or plain noise. Both sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench
    import hfcc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BEATS = 1200;
    localparam int MAX_IDLE     = 13;
    localparam int TAIL_CYCLES  = 8;

    // ---- clock, reset and block inputs, all known from time zero ----
    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               push          = 1'b0;
    logic [7:0]         i_rx_byte     = 8'h00;
    logic               i_read_failed = 1'b0;
    logic               pop           = 1'b0;
    logic               full;
    logic               empty;
    logic signed [14:0] o_temperature_centi;
    logic [13:0]        o_humidity_centi;
    logic [1:0]         o_error_code;

    always #5 i_clk = ~i_clk;

    humidity_frame_crc_converter dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .push                (push),
        .full                (full),
        .i_rx_byte           (i_rx_byte),
        .i_read_failed       (i_read_failed),
        .empty               (empty),
        .pop                 (pop),
        .o_temperature_centi (o_temperature_centi),
        .o_humidity_centi    (o_humidity_centi),
        .o_error_code        (o_error_code)
    );

    // ---- predicted frame state, mirrors the block's view of the frame ----
    logic [2:0]  frame_pos  = POS_T_HI;
    logic [7:0]  frame_crc  = CRC_INIT;
    logic [15:0] temp_raw   = 16'h0000;
    logic [7:0]  hum_hi     = 8'h00;
    logic [7:0]  hum_lo     = 8'h00;
    logic        temp_bad   = 1'b0;

    t_result     pending_readings[$];

    // both sides look at this; set means back-to-back beats with no idling
    bit          tight_mode = 1'b0;

    int          mismatch_count = 0;
    int          beats_sent     = 0;
    int          readings_seen  = 0;
    int          code_tally[4]  = '{0, 0, 0, 0};

    // CRC-8, poly 0x31, MSB first: one bit of the byte folded in per step
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[7] ^ b[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] word_crc(input logic [15:0] w);
        return crc8_next(crc8_next(CRC_INIT, w[15:8]), w[7:0]);
    endfunction

    task automatic restart_prediction();
        frame_pos = POS_T_HI;
        frame_crc = CRC_INIT;
        temp_bad  = 1'b0;
    endtask

    // Advance the predicted frame by one accepted beat; queue a reading when
    // the frame completes or aborts.
    task automatic track_frame_byte(input logic [7:0] b, input logic failed);
        t_result r;
        int      tc;
        int      hc;
        r = '0;
        if (failed) begin
            // short read: byte ignored, frame restarts, values zero
            r.error_code = ERR_SHORT;
            pending_readings.push_back(r);
            restart_prediction();
            return;
        end
        if (frame_pos > POS_H_CRC) begin
            frame_pos = POS_T_HI;
        end
        case (frame_pos)
            POS_T_HI: begin
                temp_raw[15:8] = b;
                frame_crc      = crc8_next(frame_crc, b);
            end
            POS_T_LO: begin
                temp_raw[7:0] = b;
                frame_crc     = crc8_next(frame_crc, b);
            end
            POS_T_CRC: begin
                temp_bad  = (b != frame_crc);
                frame_crc = CRC_INIT;
            end
            POS_H_HI: begin
                hum_hi    = b;
                frame_crc = crc8_next(frame_crc, b);
            end
            POS_H_LO: begin
                hum_lo    = b;
                frame_crc = crc8_next(frame_crc, b);
            end
            default: begin
                // temperature CRC is reported ahead of humidity CRC
                if (temp_bad) begin
                    r.error_code = ERR_T_CRC;
                end else if (b != frame_crc) begin
                    r.error_code = ERR_H_CRC;
                end else begin
                    r.error_code = ERR_OK;
                    tc = ((4375 * int'(temp_raw)) >> 14) - 4500;
                    hc = (625 * int'({hum_hi, hum_lo})) >> 12;
                    r.temperature_centi = 15'(tc);
                    r.humidity_centi    = 14'(hc);
                end
                pending_readings.push_back(r);
                restart_prediction();
                return;
            end
        endcase
        frame_pos = frame_pos + 3'd1;
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("%0t ns MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // One beat on the input side. Called at a falling edge, returns at one.
    task automatic send_beat(input logic [7:0] b, input logic failed);
        int gap;
        gap = tight_mode ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap > 0) begin
            // idle: junk on the payload must be ignored
            push          <= 1'b0;
            i_rx_byte     <= 8'($urandom);
            i_read_failed <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        push          <= 1'b1;
        i_rx_byte     <= b;
        i_read_failed <= failed;
        do @(posedge i_clk); while (full);
        track_frame_byte(b, failed);
        beats_sent++;
        @(negedge i_clk);
    endtask

    // Six-byte frame; a nonzero xor corrupts the matching CRC byte.
    task automatic send_frame(input logic [15:0] t_word, input logic [15:0] h_word,
                              input logic [7:0] t_xor, input logic [7:0] h_xor);
        send_beat(t_word[15:8], 1'b0);
        send_beat(t_word[7:0], 1'b0);
        send_beat(word_crc(t_word) ^ t_xor, 1'b0);
        send_beat(h_word[15:8], 1'b0);
        send_beat(h_word[7:0], 1'b0);
        send_beat(word_crc(h_word) ^ h_xor, 1'b0);
    endtask

    // ---- result side: random stalls, each popped beat checked in order ----
    initial begin : reading_checker
        t_result want;
        int      stall;
        @(posedge i_rst_n);
        forever begin
            stall = tight_mode ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_readings.size() == 0) begin
                flag_mismatch("reading with nothing pending, error_code",
                              int'(o_error_code), -1);
            end else begin
                want = pending_readings.pop_front();
                if (o_temperature_centi !== want.temperature_centi) begin
                    flag_mismatch("temperature_centi", int'(o_temperature_centi),
                                  int'(want.temperature_centi));
                end
                if (o_humidity_centi !== want.humidity_centi) begin
                    flag_mismatch("humidity_centi", int'(o_humidity_centi),
                                  int'(want.humidity_centi));
                end
                if (o_error_code !== want.error_code) begin
                    flag_mismatch("error_code", int'(o_error_code), int'(want.error_code));
                end
                readings_seen++;
                code_tally[want.error_code]++;
            end
            @(negedge i_clk);
        end
    end

    // ---- tests ----

    // Raw words at both ends of their range: coldest/wettest and hottest/driest.
    task automatic test_extreme_frames();
        send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00);
    endtask

    // Both CRCs wrong (temperature must win), then humidity CRC wrong alone.
    task automatic test_crc_failures();
        send_frame(16'h1234, 16'hABCD, 8'hFF, 8'h01);
        send_frame(16'h6666, 16'h8000, 8'h00, 8'h80);
    endtask

    // Abort at the first byte, then part way through a frame.
    task automatic test_short_reads();
        send_beat(8'hFF, 1'b1);
        send_beat(8'h55, 1'b0);
        send_beat(8'hAA, 1'b0);
        send_beat(8'h00, 1'b1);
    endtask

    // Mostly clean frames with random words; some corrupted, aborted or noise.
    task automatic test_random_traffic();
        int         start;
        int         kind;
        int         cut;
        logic [7:0] tx;
        logic [7:0] hx;
        start = beats_sent;
        while (beats_sent - start < RANDOM_BEATS) begin
            tight_mode = ($urandom_range(0, 4) == 0);
            kind       = $urandom_range(0, 99);
            if (kind < 65) begin
                send_frame(16'($urandom), 16'($urandom), 8'h00, 8'h00);
            end else if (kind < 80) begin
                // flip at least one bit of one or both check bytes
                tx = 8'h00;
                hx = 8'h00;
                case ($urandom_range(0, 2))
                    0: tx = 8'($urandom_range(1, 255));
                    1: hx = 8'($urandom_range(1, 255));
                    default: begin
                        tx = 8'($urandom_range(1, 255));
                        hx = 8'($urandom_range(1, 255));
                    end
                endcase
                send_frame(16'($urandom), 16'($urandom), tx, hx);
            end else if (kind < 90) begin
                cut = $urandom_range(0, 5);
                repeat (cut) send_beat(8'($urandom), 1'b0);
                send_beat(8'($urandom), 1'b1);
            end else begin
                // noise leaves the frame at an arbitrary position
                repeat ($urandom_range(1, 8)) begin
                    send_beat(8'($urandom), ($urandom_range(0, 7) == 0));
                end
            end
        end
        tight_mode = 1'b0;
    endtask

    // ---- sequence ----
    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_extreme_frames();
        test_crc_failures();
        test_short_reads();
        test_random_traffic();

        push <= 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d byte beats and checked %0d readings.", beats_sent, readings_seen);
        $display("Readings by code: ok %0d, short read %0d, temp CRC %0d, humidity CRC %0d.",
                 code_tally[ERR_OK], code_tally[ERR_SHORT], code_tally[ERR_T_CRC],
                 code_tally[ERR_H_CRC]);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #(5_000_000);
        $display("Timed out with %0d readings pending", pending_readings.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
